[src/diffusion_stencil_3d_core_defines.svh]
// Assertion macros for the 3D diffusion stencil core.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef DIFFUSION_STENCIL_3D_CORE_DEFINES_SVH
`define DIFFUSION_STENCIL_3D_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DSC3D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DSC3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dsc3d_pkg.sv]
// Shared types and constants of the 3D diffusion stencil core.
// No dependencies; used by the controller, the datapath and the top level.
package dsc3d_pkg;

  localparam int VOXEL_W    = 24;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Arithmetic widths: difference sum, rate product, scaled mean term
  localparam int D_W = VOXEL_W + 6;
  localparam int P_W = D_W + RATE_W;
  localparam int M_W = P_W - 15;

  // Window reads per result: centre plus the 27 taps of the 3x3x3 cube
  localparam int RD_ISSUES = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_RATE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VOXEL_W-1:0] voxel;
    logic                      flush;
  } in_req_t;

  typedef struct packed {
    logic signed [VOXEL_W-1:0] value;
    logic                      last;
  } out_rsp_t;

  typedef struct packed {
    logic accept;
    logic rd_init;
    logic rd_step;
    logic mul_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit;
    logic rd_done;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

[src/dsc3d_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dsc3d_ram #(
  parameter int Width = 24,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/dsc3d_ctrl.sv]
// Sequencer of the 3D diffusion stencil core: accept, window read, multiply,
// divide, result load. Depends on dsc3d_pkg.
module dsc3d_ctrl import dsc3d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     cfg_wr_i,
  input  ctl_sts_t sts_i,
  output logic     in_stall_o,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   settle_q;

  // Hold the input while busy and in the cycle after a register write
  assign in_stall_o = (state_q != ST_IDLE) || settle_q;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.accept  = in_valid_i && !in_stall_o;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && sts_i.emit) begin
          cmd_o.rd_init = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_step = 1'b1;
        if (sts_i.rd_done) begin
          cmd_o.mul_init = 1'b1;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and settle flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      settle_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      settle_q <= cfg_wr_i;
    end
  end

endmodule

[src/dsc3d_dpath.sv]
// Datapath of the 3D diffusion stencil core: registers, positions, window RAM,
// neighbour sum, shift-add multiplier, restoring divider, result register.
// Depends on dsc3d_pkg and dsc3d_ram.
module dsc3d_dpath import dsc3d_pkg::*; #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_req_t               in_req_i,
  input  ctl_cmd_t              cmd_i,
  input  logic                  out_stall_i,
  output ctl_sts_t              sts_o,
  output logic                  out_valid_o,
  output out_rsp_t              out_rsp_o
);

  localparam int XW    = $clog2(MAX_X + 1);
  localparam int YW    = $clog2(MAX_Y + 1);
  localparam int ZW    = $clog2(MAX_Z + 1);
  localparam int WIN   = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
  localparam int AW    = $clog2(WIN);
  localparam int CW    = AW + 1;
  localparam int SW    = AW + 2;
  localparam int SXYW  = $clog2(MAX_X * MAX_Y + 1);
  localparam int ITW   = $clog2(RD_ISSUES + 1);
  localparam int KW    = 5;
  localparam int MCW   = $clog2(RATE_W + 1);
  localparam int DCW   = $clog2(M_W + 1);
  localparam int RST_X = (64 > MAX_X) ? MAX_X : 64;
  localparam int RST_Y = (64 > MAX_Y) ? MAX_Y : 64;
  localparam int RST_Z = (1024 > MAX_Z) ? MAX_Z : 1024;

  // Tap position codes along one axis
  localparam logic [1:0] OFF_NEG = 2'd0;
  localparam logic [1:0] OFF_MID = 2'd1;
  localparam logic [1:0] OFF_POS = 2'd2;

  logic [XW-1:0]     sx_q;
  logic [YW-1:0]     sy_q;
  logic [ZW-1:0]     sz_q;
  logic [RATE_W-1:0] rate_q;
  logic [SXYW-1:0]   sxy_q;
  logic [XW-1:0]     x_clamp;
  logic [YW-1:0]     y_clamp;
  logic [ZW-1:0]     z_clamp;
  logic              size_wr;

  // Clamp size writes to 1..maximum
  always_comb begin
    x_clamp = (cfg_data_i == '0) ? XW'(1) :
              (cfg_data_i > CFG_DATA_W'(MAX_X)) ? XW'(MAX_X) : cfg_data_i[XW-1:0];
    y_clamp = (cfg_data_i == '0) ? YW'(1) :
              (cfg_data_i > CFG_DATA_W'(MAX_Y)) ? YW'(MAX_Y) : cfg_data_i[YW-1:0];
    z_clamp = (cfg_data_i == '0) ? ZW'(1) :
              (cfg_data_i > CFG_DATA_W'(MAX_Z)) ? ZW'(MAX_Z) : cfg_data_i[ZW-1:0];
  end

  assign size_wr = cfg_wr_i && (cfg_idx_e'(cfg_idx_i) != CFG_RATE);

  // Configuration registers and plane size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= XW'(RST_X);
      sy_q   <= YW'(RST_Y);
      sz_q   <= ZW'(RST_Z);
      rate_q <= '0;
      sxy_q  <= SXYW'(RST_X * RST_Y);
    end else begin
      sxy_q <= SXYW'(sx_q * sy_q);
      if (cfg_wr_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SIZE_X: sx_q   <= x_clamp;
          CFG_SIZE_Y: sy_q   <= y_clamp;
          CFG_SIZE_Z: sz_q   <= z_clamp;
          CFG_RATE:   rate_q <= cfg_data_i[RATE_W-1:0];
          default:    rate_q <= rate_q;
        endcase
      end
    end
  end

  // Stream positions and window pointers
  logic [XW-1:0] in_col_q, out_col_q;
  logic [YW-1:0] in_row_q, out_row_q;
  logic [ZW-1:0] in_plane_q, out_plane_q;
  logic [AW-1:0] wptr_q, optr_q;
  logic [CW-1:0] cnt_q, cnt_new, lag;
  logic          in_done, in_done_new, wr, in_col_end, in_row_end;
  logic          out_col_end, out_row_end, out_last;

  assign in_done     = (in_plane_q == sz_q);
  assign wr          = cmd_i.accept && !in_req_i.flush && !in_done;
  assign in_col_end  = (in_col_q == sx_q - XW'(1));
  assign in_row_end  = (in_row_q == sy_q - YW'(1));
  assign in_done_new = wr ? (in_col_end && in_row_end && (in_plane_q + ZW'(1) == sz_q))
                          : in_done;
  assign cnt_new     = cnt_q + CW'(wr);
  assign lag         = CW'(sxy_q) + CW'(sx_q) + CW'(1);
  assign out_col_end = (out_col_q == sx_q - XW'(1));
  assign out_row_end = (out_row_q == sy_q - YW'(1));
  assign out_last    = out_col_end && out_row_end && (out_plane_q == sz_q - ZW'(1));

  assign sts_o.emit  = in_done_new || (cnt_new > lag);

  // Advance input on a stored voxel, output on a loaded result; drop all on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_plane_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_plane_q <= '0;
      wptr_q      <= '0;
      optr_q      <= '0;
      cnt_q       <= '0;
    end else if (size_wr || (cmd_i.load_out && out_last)) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_plane_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_plane_q <= '0;
      wptr_q      <= '0;
      optr_q      <= '0;
      cnt_q       <= '0;
    end else if (cmd_i.load_out) begin
      cnt_q  <= cnt_q - CW'(1);
      optr_q <= (optr_q == AW'(WIN - 1)) ? '0 : optr_q + AW'(1);
      if (out_col_end) begin
        out_col_q <= '0;
        if (out_row_end) begin
          out_row_q   <= '0;
          out_plane_q <= out_plane_q + ZW'(1);
        end else begin
          out_row_q <= out_row_q + YW'(1);
        end
      end else begin
        out_col_q <= out_col_q + XW'(1);
      end
    end else if (wr) begin
      cnt_q  <= cnt_new;
      wptr_q <= (wptr_q == AW'(WIN - 1)) ? '0 : wptr_q + AW'(1);
      if (in_col_end) begin
        in_col_q <= '0;
        if (in_row_end) begin
          in_row_q   <= '0;
          in_plane_q <= in_plane_q + ZW'(1);
        end else begin
          in_row_q <= in_row_q + YW'(1);
        end
      end else begin
        in_col_q <= in_col_q + XW'(1);
      end
    end
  end

  // Window tap iteration
  logic [ITW-1:0]     it_q;
  logic [1:0]         tx_q, ty_q, tz_q;
  logic               pend_q, use_q, ctr_q;
  logic               issue, is_ctr, nbr_ok, xok, yok, zok;
  logic signed [SW-1:0] zo, yo, xo, off, raw, fixed;
  logic [AW-1:0]      raddr;
  logic [VOXEL_W-1:0] rdata;

  assign issue  = cmd_i.rd_step && (it_q != ITW'(RD_ISSUES));
  assign is_ctr = (it_q == '0);

  // Tap address in the ring and its place inside the volume
  always_comb begin
    zo = (tz_q == OFF_NEG) ? -SW'(sxy_q) : (tz_q == OFF_POS) ? SW'(sxy_q) : '0;
    yo = (ty_q == OFF_NEG) ? -SW'(sx_q)  : (ty_q == OFF_POS) ? SW'(sx_q)  : '0;
    xo = (tx_q == OFF_NEG) ? -SW'(1)     : (tx_q == OFF_POS) ? SW'(1)     : '0;
    off = is_ctr ? '0 : (zo + yo + xo);
    raw = SW'(optr_q) + off;
    if (raw < 0) begin
      fixed = raw + $signed(SW'(WIN));
    end else if (raw >= $signed(SW'(WIN))) begin
      fixed = raw - $signed(SW'(WIN));
    end else begin
      fixed = raw;
    end
    raddr = fixed[AW-1:0];
    zok = (tz_q == OFF_NEG) ? (out_plane_q != '0) :
          (tz_q == OFF_POS) ? (out_plane_q + ZW'(1) < sz_q) : 1'b1;
    yok = (ty_q == OFF_NEG) ? (out_row_q != '0) :
          (ty_q == OFF_POS) ? (out_row_q + YW'(1) < sy_q) : 1'b1;
    xok = (tx_q == OFF_NEG) ? (out_col_q != '0) :
          (tx_q == OFF_POS) ? (out_col_q + XW'(1) < sx_q) : 1'b1;
    nbr_ok = zok && yok && xok &&
             !((tx_q == OFF_MID) && (ty_q == OFF_MID) && (tz_q == OFF_MID));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q   <= '0;
      tx_q   <= OFF_NEG;
      ty_q   <= OFF_NEG;
      tz_q   <= OFF_NEG;
      pend_q <= 1'b0;
      use_q  <= 1'b0;
      ctr_q  <= 1'b0;
    end else begin
      pend_q <= issue;
      use_q  <= issue && !is_ctr && nbr_ok;
      ctr_q  <= issue && is_ctr;
      if (cmd_i.rd_init) begin
        it_q <= '0;
        tx_q <= OFF_NEG;
        ty_q <= OFF_NEG;
        tz_q <= OFF_NEG;
      end else if (issue) begin
        it_q <= it_q + ITW'(1);
        if (!is_ctr) begin
          if (tx_q == OFF_POS) begin
            tx_q <= OFF_NEG;
            if (ty_q == OFF_POS) begin
              ty_q <= OFF_NEG;
              tz_q <= tz_q + 2'd1;
            end else begin
              ty_q <= ty_q + 2'd1;
            end
          end else begin
            tx_q <= tx_q + 2'd1;
          end
        end
      end
    end
  end

  assign sts_o.rd_done = (it_q == ITW'(RD_ISSUES)) && !pend_q;

  dsc3d_ram #(
    .Width (VOXEL_W),
    .Depth (WIN)
  ) u_win (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (wptr_q),
    .wdata_i (in_req_i.voxel),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Centre and sum of neighbour differences
  logic signed [VOXEL_W-1:0] c_q;
  logic signed [D_W-1:0]     d_q;
  logic [KW-1:0]             k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_init) begin
      d_q <= '0;
      k_q <= '0;
    end else if (use_q) begin
      d_q <= d_q + {{(D_W-VOXEL_W){rdata[VOXEL_W-1]}}, rdata}
                 - {{(D_W-VOXEL_W){c_q[VOXEL_W-1]}}, c_q};
      k_q <= k_q + KW'(1);
    end
    if (ctr_q) begin
      c_q <= rdata;
    end
  end

  // Shift-add product of rate and difference sum
  logic signed [P_W-1:0] p_q, md_q;
  logic [MCW-1:0]        mcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (cmd_i.mul_init) begin
      mcnt_q <= '0;
    end else if (cmd_i.mul_step && (mcnt_q != MCW'(RATE_W))) begin
      mcnt_q <= mcnt_q + MCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init) begin
      p_q  <= '0;
      md_q <= {{(P_W-D_W){d_q[D_W-1]}}, d_q};
    end else if (cmd_i.mul_step && (mcnt_q != MCW'(RATE_W))) begin
      if (rate_q[mcnt_q[$clog2(RATE_W)-1:0]]) begin
        p_q <= p_q + md_q;
      end
      md_q <= md_q <<< 1;
    end
  end

  assign sts_o.mul_done = (mcnt_q == MCW'(RATE_W));

  // Floor division of the rounded, scaled term by the neighbour count
  logic [P_W-1:0] msum;
  logic [M_W-1:0] mval, quo_q;
  logic [KW-1:0]  rem_q;
  logic [KW:0]    trial;
  logic           sgn_q;
  logic [DCW-1:0] dcnt_q;

  assign msum  = p_q + (P_W'(k_q) << 14);
  assign mval  = msum[P_W-1:15];
  assign trial = {rem_q, quo_q[M_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_init) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step && (dcnt_q != DCW'(M_W))) begin
      dcnt_q <= dcnt_q + DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      sgn_q <= mval[M_W-1];
      quo_q <= mval[M_W-1] ? ~mval : mval;
      rem_q <= '0;
    end else if (cmd_i.div_step && (dcnt_q != DCW'(M_W))) begin
      if (trial >= {1'b0, k_q}) begin
        rem_q <= KW'(trial - {1'b0, k_q});
        quo_q <= {quo_q[M_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[KW-1:0];
        quo_q <= {quo_q[M_W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.div_done = (dcnt_q == DCW'(M_W));

  // Add to centre, saturate, load result
  logic [M_W-1:0]     qf;
  logic [M_W:0]       vsum;
  logic [VOXEL_W-1:0] vsat, vres;
  logic               out_valid_q;
  out_rsp_t           out_rsp_q;

  always_comb begin
    qf   = sgn_q ? ~quo_q : quo_q;
    vsum = {{(M_W+1-VOXEL_W){c_q[VOXEL_W-1]}}, c_q} + {qf[M_W-1], qf};
    if (vsum[M_W:VOXEL_W-1] == '0 || vsum[M_W:VOXEL_W-1] == '1) begin
      vsat = vsum[VOXEL_W-1:0];
    end else if (vsum[M_W]) begin
      vsat = {1'b1, {(VOXEL_W-1){1'b0}}};
    end else begin
      vsat = {1'b0, {(VOXEL_W-1){1'b1}}};
    end
    vres = (k_q == '0) ? c_q : vsat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rsp_q.value <= vres;
      out_rsp_q.last  <= out_last;
    end
  end

  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_rsp_o      = out_rsp_q;

endmodule

[src/diffusion_stencil_3d_core.sv]
// 3D diffusion stencil core, top level; depends on dsc3d_pkg, dsc3d_ctrl,
// dsc3d_dpath, dsc3d_ram and diffusion_stencil_3d_core_defines.svh.
// Voxels arrive in raster order; a result is centre + rate/2^15 * (mean of the
// in-volume 26 neighbours - centre), rounded and saturated, and leaves one plane
// plus one row plus one voxel behind the input, the final one marked last.
// A request that produces no result does not hold the input; one that produces
// a result holds it while the core reads centre and 27 taps through the single
// read port of the window RAM, forms the shift-add rate product, divides by the
// neighbour count bit-serially and loads the result. The input is also held in
// the cycle after any register write. Registers must be written only while the
// core is idle; the core does not enforce this. A size write restarts the volume.
// The window RAM holds 2*MAX_X*MAX_Y + 2*MAX_X + 3 voxels and needs no clearing.
`include "diffusion_stencil_3d_core_defines.svh"

module diffusion_stencil_3d_core import dsc3d_pkg::*; #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_rsp_t              out_rsp_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     cfg_wr;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  dsc3d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_wr_i   (cfg_wr),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  dsc3d_dpath #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // Checks on sequencing
  `DSC3D_ASSERT_NEXT(a_cfg_settle, cfg_wr, in_stall_o, "request taken right after a write")
  `DSC3D_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_o, "loaded result not offered")
  `DSC3D_ASSERT_NEXT(a_emit_busy, cmd.accept && sts.emit, in_stall_o, "emitting request not held")
  `DSC3D_ASSERT_SAME(a_load_alone, cmd.load_out, !cmd.accept && !cmd.rd_step, "load overlaps work")

endmodule
